>>> rtl/day_number_to_gregorian_date_assert.svh
// Assertion helpers for the day number to date converter.
// They expect clk and rst in the scope of the module that uses them.
`ifndef DAY_NUMBER_TO_GREGORIAN_DATE_ASSERT_SVH
`define DAY_NUMBER_TO_GREGORIAN_DATE_ASSERT_SVH

// same-cycle implication
`define DNGD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dngd: same-cycle check failed");

// next-cycle implication
`define DNGD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dngd: next-cycle check failed");

`endif

>>> rtl/dngd_pkg.sv
package dngd_pkg;

  localparam int MAX_YEAR = 60000;

  localparam int YEAR_W = 16;
  localparam int DAY_W  = 25;
  localparam int Q_W    = 10;   // year / 100 for any year in range
  localparam int REM_W  = 9;
  localparam int STEP_W = 4;

  // days before 1 January of MAX_YEAR + 1, i.e. the last valid day number
  localparam logic [DAY_W-1:0] LAST_DAY =
    DAY_W'(MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);

  // x / 25 == (x * RECIP_25) >> RECIP_SHIFT for x < 43690
  localparam logic [15:0] RECIP_25    = 16'd41944;
  localparam int          RECIP_SHIFT = 20;
  localparam int          PROD_W      = 30;

  localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

  typedef logic [STEP_W-1:0] step_t;

  // program addresses
  localparam step_t S_LOAD  = 4'd0;
  localparam step_t S_INIT  = 4'd1;
  localparam step_t S_MID   = 4'd2;
  localparam step_t S_MUL   = 4'd3;
  localparam step_t S_CMP   = 4'd4;
  localparam step_t S_LDY   = 4'd5;
  localparam step_t S_MUL2  = 4'd6;
  localparam step_t S_LEAP  = 4'd7;
  localparam step_t S_MONTH = 4'd8;
  localparam step_t S_EMIT  = 4'd9;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_INIT,
    OP_MID,
    OP_MUL,
    OP_CMP,
    OP_LDY,
    OP_LEAP,
    OP_MONTH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_OUT_RANGE,
    COND_SEARCH_DONE,
    COND_MONTH_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    unique case (s)
      S_LOAD:  w = '{op: OP_LOAD,  cond: COND_NO_START,    target: S_LOAD};
      S_INIT:  w = '{op: OP_INIT,  cond: COND_OUT_RANGE,   target: S_EMIT};
      S_MID:   w = '{op: OP_MID,   cond: COND_SEARCH_DONE, target: S_LDY};
      S_MUL:   w = '{op: OP_MUL,   cond: COND_NEVER,       target: S_LOAD};
      S_CMP:   w = '{op: OP_CMP,   cond: COND_ALWAYS,      target: S_MID};
      S_LDY:   w = '{op: OP_LDY,   cond: COND_NEVER,       target: S_LOAD};
      S_MUL2:  w = '{op: OP_MUL,   cond: COND_NEVER,       target: S_LOAD};
      S_LEAP:  w = '{op: OP_LEAP,  cond: COND_NEVER,       target: S_LOAD};
      S_MONTH: w = '{op: OP_MONTH, cond: COND_MONTH_MORE,  target: S_MONTH};
      S_EMIT:  w = '{op: OP_EMIT,  cond: COND_ALWAYS,      target: S_LOAD};
      default: w = '{op: OP_EMIT,  cond: COND_ALWAYS,      target: S_LOAD};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1:                   len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/day_number_to_gregorian_date.sv
// An out-of-range day number runs from load through init straight to emit; in range, it runs
//   15 or 16 binary-search probes over years at 3 steps a probe
//   (shared reciprocal multiplier), 4 steps to close the search and settle leap,
//   then 1 to 12 month steps. One request is taken at a time;
//   the next one may start in the cycle done is high.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops done;
//   the receiver cannot stall: each result is shown for exactly the one done cycle.
`include "day_number_to_gregorian_date_assert.svh"

module day_number_to_gregorian_date (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [24:0] day_number,
  output logic        done,
  output logic        in_range,
  output logic [15:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [8:0]  day_of_year,
  output logic        leap_flag
);

  // sequencer
  dngd_pkg::step_t  step;
  dngd_pkg::step_t  step_next;
  dngd_pkg::uword_t uw;
  logic             jump;

  // datapath registers
  logic [dngd_pkg::DAY_W-1:0]  d;          // latched request
  logic                        rng;        // request lies in range
  logic [dngd_pkg::YEAR_W:0]   lo;         // one bit wider: may reach MAX_YEAR + 1
  logic [dngd_pkg::YEAR_W-1:0] hi;
  logic [dngd_pkg::YEAR_W-1:0] mid;
  logic [dngd_pkg::YEAR_W-1:0] p;          // multiplier operand (year - 1, or year)
  logic [dngd_pkg::DAY_W-1:0]  p365;       // p * 365 + p / 4
  logic [dngd_pkg::Q_W-1:0]    q100;       // p / 100
  logic [dngd_pkg::YEAR_W-1:0] yr;         // best year so far
  logic [dngd_pkg::DAY_W-1:0]  best_db;    // days before yr
  logic [dngd_pkg::REM_W-1:0]  rem;
  logic [dngd_pkg::REM_W-1:0]  doy;
  logic [3:0]                  midx;       // month index 0..11
  logic                        leap;

  // combinational datapath terms
  logic [dngd_pkg::YEAR_W:0]   lo_hi_sum;
  logic [dngd_pkg::PROD_W-1:0] q_prod;
  logic [dngd_pkg::DAY_W-1:0]  db;
  logic [dngd_pkg::DAY_W-1:0]  rem_full;
  logic [16:0]                 hund_chk;
  logic [4:0]                  mlen;
  logic                        search_done;
  logic                        month_more;
  logic                        out_range;

  assign uw   = dngd_pkg::ucode(step);
  assign busy = (step != dngd_pkg::S_LOAD);

  assign lo_hi_sum   = lo + {1'b0, hi};
  assign search_done = (lo > {1'b0, hi});
  // p / 100 == (p / 4) / 25, the quotient by reciprocal multiply
  assign q_prod      = dngd_pkg::PROD_W'(p[dngd_pkg::YEAR_W-1:2])
                     * dngd_pkg::PROD_W'(dngd_pkg::RECIP_25);
  // days_before = p*365 + p/4 - p/100 + p/400
  assign db          = p365 - dngd_pkg::DAY_W'(q100)
                     + dngd_pkg::DAY_W'(q100[dngd_pkg::Q_W-1:2]);
  assign rem_full    = d - best_db;
  assign hund_chk    = 17'(q100) * 17'd100;
  assign mlen        = dngd_pkg::month_len(midx, leap);
  assign month_more  = (midx != dngd_pkg::LAST_MONTH_IDX) && (rem > dngd_pkg::REM_W'(mlen));
  assign out_range   = (d == '0) || (d > dngd_pkg::LAST_DAY);

  // next step: conditional jump or fall through
  always_comb begin
    unique case (uw.cond)
      dngd_pkg::COND_NEVER:       jump = 1'b0;
      dngd_pkg::COND_ALWAYS:      jump = 1'b1;
      dngd_pkg::COND_NO_START:    jump = !start;
      dngd_pkg::COND_OUT_RANGE:   jump = out_range;
      dngd_pkg::COND_SEARCH_DONE: jump = search_done;
      dngd_pkg::COND_MONTH_MORE:  jump = month_more;
      default:                    jump = 1'b1;
    endcase
    step_next = jump ? uw.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dngd_pkg::S_LOAD;
      done <= 1'b0;
    end else begin
      step <= step_next;
      done <= (uw.op == dngd_pkg::OP_EMIT);
    end
  end

  // datapath, driven by the op field of the control word
  always_ff @(posedge clk) begin
    unique case (uw.op)
      dngd_pkg::OP_LOAD: begin
        d <= day_number;
      end
      dngd_pkg::OP_INIT: begin
        rng     <= !out_range;
        lo      <= (dngd_pkg::YEAR_W + 1)'(1);
        hi      <= dngd_pkg::YEAR_W'(dngd_pkg::MAX_YEAR);
        yr      <= dngd_pkg::YEAR_W'(1);
        best_db <= '0;
      end
      dngd_pkg::OP_MID: begin
        mid <= lo_hi_sum[dngd_pkg::YEAR_W:1];
        p   <= lo_hi_sum[dngd_pkg::YEAR_W:1] - 1'b1;
      end
      dngd_pkg::OP_MUL: begin
        q100 <= q_prod[dngd_pkg::RECIP_SHIFT +: dngd_pkg::Q_W];
        p365 <= dngd_pkg::DAY_W'(p) * dngd_pkg::DAY_W'(365)
              + dngd_pkg::DAY_W'(p[dngd_pkg::YEAR_W-1:2]);
      end
      dngd_pkg::OP_CMP: begin
        if (db < d) begin
          yr      <= mid;
          best_db <= db;
          lo      <= {1'b0, mid} + 1'b1;
        end else begin
          hi      <= mid - 1'b1;
        end
      end
      dngd_pkg::OP_LDY: begin
        p   <= yr;   // reuse the multiplier for yr / 100
        rem <= rem_full[dngd_pkg::REM_W-1:0];
      end
      dngd_pkg::OP_LEAP: begin
        leap <= (yr[1:0] == 2'b00)
             && ((hund_chk != 17'(yr)) || (q100[1:0] == 2'b00));
        doy  <= rem;
        midx <= '0;
      end
      dngd_pkg::OP_MONTH: begin
        if (month_more) begin
          rem  <= rem - dngd_pkg::REM_W'(mlen);
          midx <= midx + 1'b1;
        end
      end
      dngd_pkg::OP_EMIT: begin
        in_range     <= rng;
        year         <= rng ? yr : '0;
        month        <= rng ? midx + 1'b1 : '0;
        day_of_month <= rng ? rem[4:0] : '0;
        day_of_year  <= rng ? doy : '0;
        leap_flag    <= rng ? leap : 1'b0;
      end
      default: begin
      end
    endcase
  end

  `DNGD_ASSERT_NOW(a_done_idle, done, !busy)
  `DNGD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `DNGD_ASSERT_NOW(a_zero_out, done && !in_range, (year == '0) && (month == '0) && (day_of_year == '0))
  `DNGD_ASSERT_NOW(a_date_ok, done && in_range, (month != '0) && (month <= 4'd12) && (day_of_month != '0))
  `DNGD_ASSERT_NOW(a_probe_in_bounds, step == dngd_pkg::S_CMP, ({1'b0, mid} >= lo) && (mid <= hi))

endmodule
